// ===== hdl/mkpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkpc_pkg
// Shared sizes, codes and address helpers for the position-specific k-mer
// counter.
// ----------------------------------------------------------------------------
package mkpc_pkg;

  localparam int MAX_ORDER  = 3;
  localparam int MAX_WIDTH  = 64;
  localparam int COUNT_BITS = 16;
  localparam int SITE_BITS  = 16;

  localparam int ORDER_W = 2;
  localparam int BASE_W  = 2;
  localparam int KMER_W  = 2 * (MAX_ORDER + 1);
  localparam int HIST_W  = 2 * MAX_ORDER;
  localparam int POS_W   = $clog2(MAX_WIDTH);
  localparam int SPOS_W  = POS_W + 1;
  localparam int MW_W    = 7;

  // Rows of the store: 4 + 16 + ... + 4^(MAX_ORDER+1).
  localparam int KMER_TOTAL  = ((1 << (2 * (MAX_ORDER + 2))) - 4) / 3;
  localparam int ROW_W       = $clog2(KMER_TOTAL);
  localparam int ADDR_W      = ROW_W + POS_W;
  localparam int STORE_DEPTH = KMER_TOTAL * MAX_WIDTH;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SITE_BITS-1:0]  SITE_MAX  = '1;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = COUNT_BITS + SITE_BITS;
  localparam int M_TUSER_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_LENGTH = 2'd1;
  localparam logic [1:0] STATUS_NARROW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_WIDTH = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_READ,
    ST_FINISH
  } state_t;

  // Mask that keeps the low 2(k+1) bits of a k-mer window.
  function automatic logic [KMER_W-1:0] kmer_mask(input logic [ORDER_W-1:0] k);
    logic [KMER_W-1:0] m;
    case (k)
      2'd0:    m = 8'h03;
      2'd1:    m = 8'h0F;
      2'd2:    m = 8'h3F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // First row of each order: sum of 4^(i+1) for i below k.
  function automatic logic [ROW_W-1:0] order_offset(input logic [ORDER_W-1:0] k);
    logic [ROW_W-1:0] o;
    case (k)
      2'd0:    o = 9'd0;
      2'd1:    o = 9'd4;
      2'd2:    o = 9'd20;
      default: o = 9'd84;
    endcase
    return o;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [ORDER_W-1:0] k,
                                                   input logic [KMER_W-1:0]  kmer,
                                                   input logic [POS_W-1:0]   pos);
    logic [ROW_W-1:0] row;
    row = order_offset(k) + ROW_W'(kmer & kmer_mask(k));
    return {row, pos};
  endfunction

endpackage

// ===== hdl/markov_kmer_position_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_kmer_position_counter
// Counts position-specific k-mers of orders 0 to model_order over binding
// sites, one base per transaction, with read-back and clear of the store.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Content
// s_*       in         s_tvalid / s_tready      opcode, base, site end, pads, query
// m_*       out        m_tvalid / m_tready      count value, sites seen, status
// cfg_*     in         cfg_valid / cfg_ready    register index and write data
//
// A counted base makes one read-modify-write of the count memory (one read
// port, one write port) per order; the write-back of one order shares a
// state with the read of the next. Other bases and unused opcodes go to
// ST_FINISH at once, a read via ST_READ. Reset and the clear opcode sweep
// all 21760 entries one entry a cycle; s_tready stays low, cfg writes are taken.
// A finished result waits in the output register while the next transaction
// is accepted; the block stalls only if a second result is ready before then.
//
module markov_kmer_position_counter (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: base[1:0], pad_bases[7:2], query_order[9:8],
  //          query_kmer[17:10], query_position[23:18]
  input  logic [mkpc_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [mkpc_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                           s_tlast,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // m_tdata: count_value[15:0], sites_seen[31:16]
  output logic [mkpc_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: status[1:0]
  output logic [mkpc_pkg::M_TUSER_W-1:0] m_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mkpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkpc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import mkpc_pkg::*;

  // Count memory.
  logic [COUNT_BITS-1:0] count_mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  mem_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  // Control and block state.
  state_t                state, state_next;
  logic [ORDER_W-1:0]    k_cnt, k_cnt_next;
  logic [ADDR_W-1:0]     clr_addr, clr_addr_next;
  logic                  clr_reply;
  logic [1:0]            op;
  logic [ORDER_W-1:0]    q_order;
  logic [KMER_W-1:0]     q_kmer;
  logic [POS_W-1:0]      q_pos;
  logic                  q_ok;
  logic [KMER_W-1:0]     window;
  logic [POS_W-1:0]      pos_lat;
  logic [ORDER_W-1:0]    k_top;
  logic [1:0]            status_r;
  logic [SPOS_W-1:0]     site_pos;
  logic [HIST_W-1:0]     hist;
  logic [SITE_BITS-1:0]  site_total;
  logic [ORDER_W-1:0]    model_order;
  logic [MW_W-1:0]       motif_width;

  // Output register.
  logic                  out_valid;
  logic [M_TDATA_W-1:0]  out_tdata;
  logic [M_TUSER_W-1:0]  out_tuser;
  logic                  out_load;

  // Input field views.
  logic [BASE_W-1:0]     in_base;
  logic [HIST_W-1:0]     in_pad;
  logic [ORDER_W-1:0]    in_qorder;
  logic [KMER_W-1:0]     in_qkmer;
  logic [POS_W-1:0]      in_qpos;
  logic                  accept;

  // Decode of a counted base at accept time.
  logic [MW_W-1:0]       width_eff;
  logic [HIST_W-1:0]     hist_in;
  logic [KMER_W-1:0]     window_in;
  logic                  narrow;
  logic                  count_en;

  assign in_base   = s_tdata[1:0];
  assign in_pad    = s_tdata[7:2];
  assign in_qorder = s_tdata[9:8];
  assign in_qkmer  = s_tdata[17:10];
  assign in_qpos   = s_tdata[23:18];

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_tdata;
  assign m_tuser  = out_tuser;

  assign width_eff = (motif_width > MW_W'(MAX_WIDTH)) ? MW_W'(MAX_WIDTH) : motif_width;
  assign hist_in   = (site_pos == '0) ? in_pad : hist;
  assign window_in = {hist_in, in_base};
  assign narrow    = width_eff < (MW_W'(model_order) + MW_W'(1));
  assign count_en  = !narrow && (MW_W'(site_pos) < width_eff);

  // Sequencer: next state, memory port control and output load.
  always_comb begin
    state_next    = state;
    k_cnt_next    = k_cnt;
    clr_addr_next = clr_addr;
    s_tready      = 1'b0;
    mem_we        = 1'b0;
    wr_addr       = store_addr(k_cnt, window, pos_lat);
    wr_data       = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 1'b1;
    rd_en         = 1'b0;
    rd_addr       = store_addr(k_cnt, window, pos_lat);
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          k_cnt_next = '0;
          case (s_tuser)
            OP_COUNT: state_next = count_en ? ST_CNT_RD : ST_FINISH;
            OP_READ:  state_next = ST_READ;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_addr_next = '0;
          state_next    = clr_reply ? ST_FINISH : ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_CNT_RD: begin
        rd_en      = 1'b1;
        state_next = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        // Write back order k while fetching order k+1; the orders never
        // share an address.
        mem_we = 1'b1;
        if (k_cnt == k_top) begin
          state_next = ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = store_addr(k_cnt + 1'b1, window, pos_lat);
          k_cnt_next = k_cnt + 1'b1;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        rd_addr    = store_addr(q_order, q_kmer, q_pos);
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      k_cnt     <= '0;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else begin
      state    <= state_next;
      k_cnt    <= k_cnt_next;
      clr_addr <= clr_addr_next;
      if (accept) begin
        clr_reply <= (s_tuser == OP_CLEAR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata <= count_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_order <= 2'd2;
      motif_width <= 7'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODEL_ORDER: model_order <= cfg_data[1:0];
        CFG_MOTIF_WIDTH: motif_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Site tracking and per-transaction operands, all settled at accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      site_pos   <= '0;
      hist       <= '0;
      site_total <= '0;
      status_r   <= STATUS_OK;
      op         <= '0;
    end else if (accept) begin
      op       <= s_tuser;
      status_r <= STATUS_OK;
      if (s_tuser == OP_COUNT) begin
        if (narrow) begin
          status_r <= STATUS_NARROW;
        end
        if (s_tlast) begin
          if (!narrow) begin
            if (MW_W'(site_pos) + MW_W'(1) == width_eff) begin
              if (site_total != SITE_MAX) begin
                site_total <= site_total + 1'b1;
              end
            end else begin
              status_r <= STATUS_LENGTH;
            end
          end
          site_pos <= '0;
          hist     <= '0;
        end else begin
          hist <= window_in[HIST_W-1:0];
          if (site_pos != SPOS_W'(MAX_WIDTH)) begin
            site_pos <= site_pos + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window  <= window_in;
      pos_lat <= site_pos[POS_W-1:0];
      k_top   <= model_order;
      q_order <= in_qorder;
      q_kmer  <= in_qkmer;
      q_pos   <= in_qpos;
      q_ok    <= (in_qkmer & ~kmer_mask(in_qorder)) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata[COUNT_BITS-1:0] <= ((op == OP_READ) && q_ok) ? mem_rdata : '0;
      out_tdata[M_TDATA_W-1:COUNT_BITS] <= site_total;
      out_tuser <= status_r;
    end
  end

  // The block never accepts input in the cycle after it has taken a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // The order loop never runs past the order latched for the base.
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CNT_WR) |-> (k_cnt <= k_top))
    else $error("order counter beyond latched model order");

  // Site position saturates at the largest motif width.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    site_pos <= SPOS_W'(MAX_WIDTH))
    else $error("site position above maximum width");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || m_tready))
    else $error("pending result overwritten");

endmodule
